// ===== src/pfgb_pkg.sv =====
// Package for the page-layout framebuffer glyph blitter.
// Panel geometry, derived widths, request codes and the lane merge type.
// No dependencies.
package pfgb_pkg;

  // panel geometry
  localparam int PANEL_WIDTH    = 128;
  localparam int PANEL_PAGES    = 8;
  localparam int MAX_ROW_PIXELS = 16;

  // fixed field widths
  localparam int RowBitsW = 16;
  localparam int WidthW   = 5;
  localparam int CountW   = 5;

  // derived sizes
  localparam int PanelRows  = PANEL_PAGES * 8;
  localparam int StoreBytes = PANEL_WIDTH * PANEL_PAGES;
  localparam int AddrW      = $clog2(StoreBytes);
  localparam int NumLanes   = (MAX_ROW_PIXELS < RowBitsW) ? MAX_ROW_PIXELS : RowBitsW;
  localparam int LaneW      = $clog2(NumLanes);
  localparam int PtrW       = $clog2(NumLanes + 1);

  // request codes
  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_DRAW  = 2'd1,
    REQ_READ  = 2'd2
  } req_e;

  // merged lane result: which lanes hit and how many
  typedef struct packed {
    logic [NumLanes-1:0] mask;
    logic [CountW-1:0]   count;
  } merge_t;

endpackage

// ===== src/pfgb_if.sv =====
// Request and response channel interfaces of the glyph blitter.
// Valid/ready handshake; depends on nothing.
interface pfgb_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic signed [9:0] pos_x;
  logic signed [7:0] pos_y;
  logic [15:0]       row_bits;
  logic [4:0]        row_width;
  logic [9:0]        read_index;

  modport source (output valid, req_type, pos_x, pos_y, row_bits, row_width, read_index,
                  input ready);
  modport sink   (input valid, req_type, pos_x, pos_y, row_bits, row_width, read_index,
                  output ready);
endinterface

interface pfgb_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [4:0] pixels_set;

  modport source (output valid, read_data, pixels_set, input ready);
  modport sink   (input valid, read_data, pixels_set, output ready);
endinterface

// ===== src/pfgb_lane.sv =====
// One blitter lane: decides whether one glyph column lands on the panel.
// Depends on pfgb_pkg.
module pfgb_lane (
  input  logic [pfgb_pkg::LaneW-1:0]    lane_idx_i,
  input  logic signed [9:0]             pos_x_i,
  input  logic                          y_ok_i,
  input  logic [pfgb_pkg::RowBitsW-1:0] row_bits_i,
  input  logic [pfgb_pkg::WidthW-1:0]   width_i,
  output logic                          hit_o
);
  import pfgb_pkg::*;

  logic signed [10:0] x;
  logic               x_ok;
  logic               bit_set;
  logic               in_width;

  // column position of this lane
  assign x = {pos_x_i[9], pos_x_i} + 11'(lane_idx_i);
  assign x_ok = !x[10] && (32'(x) < PANEL_WIDTH);

  // glyph bit, leftmost column is the top bit
  assign bit_set  = row_bits_i[4'(RowBitsW - 1) - 4'(lane_idx_i)];
  assign in_width = WidthW'(lane_idx_i) < width_i;

  assign hit_o = y_ok_i && bit_set && in_width && x_ok;

endmodule

// ===== src/pfgb_merge.sv =====
// Merge stage: gathers lane hits into a write mask and a pixel count.
// Depends on pfgb_pkg.
module pfgb_merge (
  input  logic [pfgb_pkg::NumLanes-1:0] hits_i,
  output pfgb_pkg::merge_t              merge_o
);
  import pfgb_pkg::*;

  // count lanes that land on the panel
  always_comb begin
    merge_o.mask  = hits_i;
    merge_o.count = CountW'($countones(hits_i));
  end

endmodule

// ===== src/pfgb_store.sv =====
// Frame store memory: one write port, one read port, registered read data.
// Depends on pfgb_pkg.
module pfgb_store (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [pfgb_pkg::AddrW-1:0] waddr_i,
  input  logic [7:0]                 wdata_i,
  input  logic                       re_i,
  input  logic [pfgb_pkg::AddrW-1:0] raddr_i,
  output logic [7:0]                 rdata_o
);
  import pfgb_pkg::*;

  logic [7:0] mem [StoreBytes];
  logic [7:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/page_framebuffer_glyph_blitter.sv =====
// 128x64 monochrome framebuffer in page layout with a glyph-row blitter: each
// byte holds eight vertical pixels, pixel (x,y) being bit y%8 of byte
// (y/8)*128+x. One request is handled at a time and each gives one response.
// In a draw, 16 lanes test all glyph columns at once, then
// the hit bytes go through a pipelined read-modify-write on the store's
// single write port, one lane per cycle. A clear writes one byte per cycle.
// After reset the store runs a clearing pass during which no request is taken.
// The response sits in an output register, so a request can be taken while it
// waits.
module page_framebuffer_glyph_blitter (
  input  logic  clk_i,
  input  logic  rst_ni,
  pfgb_req_if.sink   req_i,
  pfgb_rsp_if.source rsp_o
);
  import pfgb_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_LANES,
    S_RMW,
    S_READ,
    S_RDATA,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  // captured request
  logic signed [9:0]   pos_x_q, pos_x_d;
  logic signed [7:0]   pos_y_q, pos_y_d;
  logic [RowBitsW-1:0] row_bits_q, row_bits_d;
  logic [WidthW-1:0]   width_q, width_d;
  logic [9:0]          read_index_q, read_index_d;

  // draw and clear sequencing
  logic [NumLanes-1:0] hit_q, hit_d;
  logic [AddrW-1:0]    base_q, base_d;
  logic [PtrW-1:0]     ptr_q, ptr_d;
  logic                wr_pend_q, wr_pend_d;
  logic [AddrW-1:0]    wr_addr_q, wr_addr_d;
  logic [AddrW-1:0]    clr_ptr_q, clr_ptr_d;

  // pending result and output register
  logic [7:0]        res_data_q, res_data_d;
  logic [CountW-1:0] res_cnt_q, res_cnt_d;
  logic              rsp_valid_q, rsp_valid_d;
  logic [7:0]        rsp_data_q, rsp_data_d;
  logic [CountW-1:0] rsp_cnt_q, rsp_cnt_d;

  // memory port
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [7:0]       mem_wdata;
  logic             mem_re;
  logic [AddrW-1:0] mem_raddr;
  logic [7:0]       mem_rdata;

  logic [WidthW-1:0]   width_sat;
  logic                y_ok;
  logic [NumLanes-1:0] lane_hits;
  merge_t              merged;
  logic [7:0]          pix_mask;
  logic [LaneW-1:0]    ptr_idx;
  logic signed [10:0]  rmw_x;
  logic [AddrW-1:0]    rmw_addr;
  logic                rmw_re;
  logic                read_in_range;

  // row checks shared by all lanes
  assign width_sat = (width_q > WidthW'(NumLanes)) ? WidthW'(NumLanes) : width_q;
  assign y_ok      = !pos_y_q[7] && (32'(pos_y_q[6:0]) < PanelRows);
  assign pix_mask  = 8'(1) << pos_y_q[2:0];

  // lanes, one per glyph column
  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    pfgb_lane u_lane (
      .lane_idx_i (LaneW'(g)),
      .pos_x_i    (pos_x_q),
      .y_ok_i     (y_ok),
      .row_bits_i (row_bits_q),
      .width_i    (width_sat),
      .hit_o      (lane_hits[g])
    );
  end

  pfgb_merge u_merge (
    .hits_i  (lane_hits),
    .merge_o (merged)
  );

  // read-modify-write address for the current lane
  assign ptr_idx  = ptr_q[LaneW-1:0];
  assign rmw_x    = {pos_x_q[9], pos_x_q} + 11'(ptr_q);
  assign rmw_addr = base_q + AddrW'(rmw_x);
  assign rmw_re   = (ptr_q != PtrW'(NumLanes)) && hit_q[ptr_idx];

  assign read_in_range = 32'(read_index_q) < StoreBytes;

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_ptr_q;
    mem_wdata = 8'd0;
    mem_re    = 1'b0;
    mem_raddr = rmw_addr;
    case (state_q)
      S_INIT, S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_RMW: begin
        mem_we    = wr_pend_q;
        mem_waddr = wr_addr_q;
        mem_wdata = mem_rdata | pix_mask;
        mem_re    = rmw_re;
      end
      S_READ: begin
        mem_re    = 1'b1;
        mem_raddr = AddrW'(read_index_q);
      end
      default: ;
    endcase
  end

  pfgb_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // sequencer next state
  always_comb begin
    state_d      = state_q;
    pos_x_d      = pos_x_q;
    pos_y_d      = pos_y_q;
    row_bits_d   = row_bits_q;
    width_d      = width_q;
    read_index_d = read_index_q;
    hit_d        = hit_q;
    base_d       = base_q;
    ptr_d        = ptr_q;
    wr_pend_d    = wr_pend_q;
    wr_addr_d    = wr_addr_q;
    clr_ptr_d    = clr_ptr_q;
    res_data_d   = res_data_q;
    res_cnt_d    = res_cnt_q;
    rsp_valid_d  = rsp_valid_q;
    rsp_data_d   = rsp_data_q;
    rsp_cnt_d    = rsp_cnt_q;

    // response transfer frees the output register
    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    case (state_q)
      S_INIT, S_CLEAR: begin
        clr_ptr_d = clr_ptr_q + AddrW'(1);
        if (clr_ptr_q == AddrW'(StoreBytes - 1)) begin
          state_d = (state_q == S_INIT) ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        if (req_i.valid) begin
          pos_x_d      = req_i.pos_x;
          pos_y_d      = req_i.pos_y;
          row_bits_d   = req_i.row_bits;
          width_d      = req_i.row_width;
          read_index_d = req_i.read_index;
          res_data_d   = 8'd0;
          res_cnt_d    = '0;
          case (req_i.req_type)
            REQ_CLEAR: begin
              clr_ptr_d = '0;
              state_d   = S_CLEAR;
            end
            REQ_DRAW:  state_d = S_LANES;
            REQ_READ:  state_d = S_READ;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_LANES: begin
        hit_d     = merged.mask;
        res_cnt_d = merged.count;
        base_d    = AddrW'(32'(pos_y_q[6:3]) * PANEL_WIDTH);
        ptr_d     = '0;
        wr_pend_d = 1'b0;
        state_d   = S_RMW;
      end
      S_RMW: begin
        wr_pend_d = rmw_re;
        wr_addr_d = rmw_addr;
        if (ptr_q == PtrW'(NumLanes)) begin
          wr_pend_d = 1'b0;
          state_d   = S_DONE;
        end else begin
          ptr_d = ptr_q + PtrW'(1);
        end
      end
      S_READ: begin
        state_d = S_RDATA;
      end
      S_RDATA: begin
        res_data_d = read_in_range ? mem_rdata : 8'd0;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          rsp_data_d  = res_data_q;
          rsp_cnt_d   = res_cnt_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      pos_x_q      <= '0;
      pos_y_q      <= '0;
      row_bits_q   <= '0;
      width_q      <= '0;
      read_index_q <= '0;
      hit_q        <= '0;
      base_q       <= '0;
      ptr_q        <= '0;
      wr_pend_q    <= 1'b0;
      wr_addr_q    <= '0;
      clr_ptr_q    <= '0;
      res_data_q   <= '0;
      res_cnt_q    <= '0;
      rsp_valid_q  <= 1'b0;
      rsp_data_q   <= '0;
      rsp_cnt_q    <= '0;
    end else begin
      state_q      <= state_d;
      pos_x_q      <= pos_x_d;
      pos_y_q      <= pos_y_d;
      row_bits_q   <= row_bits_d;
      width_q      <= width_d;
      read_index_q <= read_index_d;
      hit_q        <= hit_d;
      base_q       <= base_d;
      ptr_q        <= ptr_d;
      wr_pend_q    <= wr_pend_d;
      wr_addr_q    <= wr_addr_d;
      clr_ptr_q    <= clr_ptr_d;
      res_data_q   <= res_data_d;
      res_cnt_q    <= res_cnt_d;
      rsp_valid_q  <= rsp_valid_d;
      rsp_data_q   <= rsp_data_d;
      rsp_cnt_q    <= rsp_cnt_d;
    end
  end

  // channel outputs
  assign req_i.ready      = (state_q == S_IDLE);
  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.read_data  = rsp_data_q;
  assign rsp_o.pixels_set = rsp_cnt_q;

  // no store write while waiting for a request
  a_idle_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !mem_we)
    else $error("store written while idle");

  // pipelined read-modify-write never reads the byte it writes
  a_rmw_distinct : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we && mem_re |-> mem_raddr != mem_waddr)
    else $error("read-modify-write address collision");

  // one request in flight at a time
  a_one_inflight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request taken while busy");

  // a response never carries both read data and a pixel count
  a_rsp_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.read_data == 8'd0 || rsp_o.pixels_set == '0))
    else $error("response mixes read and draw results");

  // pixel count bounded by lane count
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> 32'(rsp_o.pixels_set) <= NumLanes)
    else $error("pixel count exceeds lanes");

endmodule

// ===== test/page_framebuffer_glyph_blitter_checker.sv =====
// Response checker for the page-layout framebuffer glyph blitter.
// Keeps its own copy of the frame store and compares every response transfer.
// Depends on pfgb_pkg and the pfgb_req_if / pfgb_rsp_if interfaces.
module page_framebuffer_glyph_blitter_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  pfgb_req_if         req_i,
  pfgb_rsp_if         rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import pfgb_pkg::*;

  typedef struct packed {
    logic [7:0]        read_data;
    logic [CountW-1:0] pixels_set;
  } reply_t;

  logic [7:0]  panel_bytes [StoreBytes];
  reply_t      expected_replies [$];
  int unsigned mismatches;

  // OR one glyph row into the store copy, return the on-panel pixel count
  function automatic logic [CountW-1:0] blit_row(int x0, int y, logic [RowBitsW-1:0] bits,
                                                 int width);
    int lanes;
    int x;
    logic [CountW-1:0] lit;
    lanes = (MAX_ROW_PIXELS < RowBitsW) ? MAX_ROW_PIXELS : RowBitsW;
    lit   = '0;
    if (width > lanes) width = lanes;
    if (y < 0 || y >= PanelRows) return '0;
    for (int col = 0; col < width; col++) begin
      x = x0 + col;
      if (bits[RowBitsW-1-col] && x >= 0 && x < PANEL_WIDTH) begin
        panel_bytes[(y / 8) * PANEL_WIDTH + x][y % 8] = 1'b1;
        lit++;
      end
    end
    return lit;
  endfunction

  // apply one request to the store copy and build the reply it should give
  function automatic reply_t reply_for(logic [1:0] kind, logic signed [9:0] pos_x,
                                       logic signed [7:0] pos_y, logic [15:0] row_bits,
                                       logic [4:0] row_width, logic [9:0] read_index);
    reply_t r;
    r = '0;
    case (kind)
      REQ_CLEAR: begin
        foreach (panel_bytes[i]) panel_bytes[i] = '0;
      end
      REQ_DRAW: begin
        r.pixels_set = blit_row(int'(pos_x), int'(pos_y), row_bits, int'(row_width));
      end
      REQ_READ: begin
        if (int'(read_index) < StoreBytes) r.read_data = panel_bytes[read_index];
      end
      default: ;
    endcase
    return r;
  endfunction

  // response compare first, then prediction of the newly taken request
  always @(posedge clk_i or negedge rst_ni) begin : watch
    reply_t want;
    if (!rst_ni) begin
      foreach (panel_bytes[i]) panel_bytes[i] = '0;
      expected_replies.delete();
      mismatches = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: response expected none got read_data %0h pixels_set %0d", $time,
                   rsp_i.read_data, rsp_i.pixels_set);
          mismatches++;
        end else begin
          want = expected_replies.pop_front();
          if (rsp_i.read_data !== want.read_data) begin
            $display("%0t: read_data expected %0h got %0h", $time, want.read_data,
                     rsp_i.read_data);
            mismatches++;
          end
          if (rsp_i.pixels_set !== want.pixels_set) begin
            $display("%0t: pixels_set expected %0d got %0d", $time, want.pixels_set,
                     rsp_i.pixels_set);
            mismatches++;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        expected_replies.push_back(reply_for(req_i.req_type, req_i.pos_x, req_i.pos_y,
                                             req_i.row_bits, req_i.row_width,
                                             req_i.read_index));
      end
    end
    fail_count_o = mismatches;
    pending_o    = expected_replies.size();
  end

endmodule

// ===== test/page_framebuffer_glyph_blitter_test.sv =====
// Testbench top for the page-layout framebuffer glyph blitter.
// Drives directed and random requests with random idling; the checker module
// predicts and compares. Depends on pfgb_pkg, the interfaces and the checker.
module page_framebuffer_glyph_blitter_test;
  import pfgb_pkg::*;

  localparam int unsigned RANDOM_ITEMS    = 1800;
  localparam int unsigned HOLD_OFF_AFTER  = 500;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES    = 64;
  localparam logic [1:0]  REQ_UNUSED      = 2'd3;

  typedef struct {
    logic [1:0]        kind;
    logic signed [9:0] pos_x;
    logic signed [7:0] pos_y;
    logic [15:0]       row_bits;
    logic [4:0]        row_width;
    logic [9:0]        read_index;
  } blit_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned items_sent;
  int unsigned sender_calm;
  int unsigned receiver_calm;

  pfgb_req_if req_if ();
  pfgb_rsp_if rsp_if ();

  page_framebuffer_glyph_blitter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  page_framebuffer_glyph_blitter_checker compare_unit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #10 clk_i = ~clk_i;

  // reset once at the start
  initial begin
    rst_ni <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // idle cycles before the next transfer, with occasional calm stretches
  function automatic int unsigned draw_gap(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(20, 80);
    return $urandom_range(0, 7);
  endfunction

  function automatic blit_req_t make_req(logic [1:0] kind, int x, int y, int bits, int width,
                                         int index);
    blit_req_t r;
    r.kind       = kind;
    r.pos_x      = 10'(x);
    r.pos_y      = 8'(y);
    r.row_bits   = 16'(bits);
    r.row_width  = 5'(width);
    r.read_index = 10'(index);
    return r;
  endfunction

  function automatic blit_req_t random_req(logic [1:0] kind);
    return make_req(kind, int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                    int'($urandom));
  endfunction

  // offer one request and hold it until the transfer
  task automatic send_request(input blit_req_t r);
    int unsigned gap;
    gap = draw_gap(sender_calm);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.req_type   <= r.kind;
    req_if.pos_x      <= r.pos_x;
    req_if.pos_y      <= r.pos_y;
    req_if.row_bits   <= r.row_bits;
    req_if.row_width  <= r.row_width;
    req_if.read_index <= r.read_index;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    items_sent++;
  endtask

  // request side
  initial begin : stimulus
    blit_req_t item;
    int pick, gx, gy, rows, cols, px, py;
    req_if.valid      <= 1'b0;
    req_if.req_type   <= REQ_CLEAR;
    req_if.pos_x      <= '0;
    req_if.pos_y      <= '0;
    req_if.row_bits   <= '0;
    req_if.row_width  <= '0;
    req_if.read_index <= '0;
    sender_calm = 0;
    items_sent  = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // directed: corners, clipping on every side, width extremes, unused code
    send_request(make_req(REQ_READ,     0,    0, 'h0000,  0,    0));
    send_request(make_req(REQ_DRAW,     0,    0, 'hFFFF, 16,    0));
    send_request(make_req(REQ_READ,     0,    0, 'h0000,  0,    0));
    send_request(make_req(REQ_READ,     0,    0, 'h0000,  0,   15));
    send_request(make_req(REQ_DRAW,   120,   63, 'hFFFF, 16,    0));
    send_request(make_req(REQ_READ,     0,    0, 'h0000,  0, 1023));
    send_request(make_req(REQ_DRAW,  -512,    5, 'hFFFF, 16,    0));
    send_request(make_req(REQ_DRAW,    -8,   10, 'hFFFF, 16,    0));
    send_request(make_req(REQ_DRAW,   511,   10, 'hFFFF, 16,    0));
    send_request(make_req(REQ_DRAW,    40, -128, 'hFFFF, 16,    0));
    send_request(make_req(REQ_DRAW,    40,  127, 'hFFFF, 16,    0));
    send_request(make_req(REQ_DRAW,    40,   64, 'hFFFF, 16,    0));
    send_request(make_req(REQ_DRAW,    40,   -1, 'hFFFF, 16,    0));
    send_request(make_req(REQ_DRAW,    50,   20, 'hFFFF,  0,    0));
    send_request(make_req(REQ_DRAW,    50,   20, 'hFFFF, 31,    0));
    send_request(make_req(REQ_DRAW,    70,   21, 'hFFFF, 17,    0));
    send_request(make_req(REQ_DRAW,    90,   30, 'h8000,  1,    0));
    send_request(make_req(REQ_DRAW,    90,   31, 'h0001, 16,    0));
    send_request(make_req(REQ_DRAW,    60,   33, 'hAAAA, 16,    0));
    send_request(make_req(REQ_UNUSED,  -1,   -1, 'hFFFF, 31, 1023));
    send_request(make_req(REQ_READ,     0,    0, 'h0000,  0, 2 * 128 + 50));
    send_request(make_req(REQ_READ,     0,    0, 'h0000,  0, 4 * 128 + 61));
    send_request(make_req(REQ_CLEAR,    0,    0, 'h0000,  0,    0));
    send_request(make_req(REQ_READ,     0,    0, 'h0000,  0,    0));
    send_request(make_req(REQ_READ,     0,    0, 'h0000,  0, 1023));

    // random: mostly whole glyphs near the panel followed by read-back
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        gx   = int'($urandom_range(0, 143)) - 8;
        gy   = int'($urandom_range(0, 75)) - 6;
        rows = $urandom_range(6, 16);
        cols = $urandom_range(5, 16);
        for (int r = 0; r < rows; r++) begin
          item           = random_req(REQ_DRAW);
          item.pos_x     = 10'(gx);
          item.pos_y     = 8'(gy + r);
          item.row_width = 5'(cols);
          send_request(item);
        end
        repeat ($urandom_range(1, 3)) begin
          px   = gx + int'($urandom_range(0, cols - 1));
          py   = gy + int'($urandom_range(0, rows - 1));
          item = random_req(REQ_READ);
          if (px >= 0 && px < PANEL_WIDTH && py >= 0 && py < PanelRows)
            item.read_index = 10'((py / 8) * PANEL_WIDTH + px);
          send_request(item);
        end
      end else if (pick < 75) begin
        send_request(random_req(REQ_READ));
      end else if (pick < 93) begin
        send_request(random_req(REQ_DRAW));
      end else if (pick < 98) begin
        send_request(random_req(REQ_UNUSED));
      end else begin
        send_request(random_req(REQ_CLEAR));
      end
    end
    req_if.valid <= 1'b0;

    // drain, then watch a while for stray responses
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // response side, with one long hold-off to back the block up
  initial begin : response_sink
    int unsigned gap;
    int unsigned taken;
    rsp_if.ready <= 1'b0;
    receiver_calm = 0;
    taken = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = draw_gap(receiver_calm);
      if (taken == HOLD_OFF_AFTER) gap = HOLD_OFF_CYCLES;
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (rsp_if.valid !== 1'b1);
      taken++;
    end
  end

  // hard stop
  initial begin
    #200_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
